FILE: rtl/bmpca_pkg.sv
// Shared constants, types and helpers for the banded min path cost block.
`default_nettype none
package bmpca_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_REACH = 63;

    localparam int COST_W  = 32;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ROWS_W  = 11;
    localparam int REACH_W = 6;
    localparam int ADDR_W  = ROW_W + 1;

    // register indexes on the config port
    localparam logic REG_ROWS_IN_USE      = 1'b0;
    localparam logic REG_EMPTY_WINDOW_CST = 1'b1;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         lo;
        logic [ROW_W-1:0]         hi;
        logic                     in_band;
        logic                     scan;
        logic                     last;
        logic                     bank;
    } cmd_t;

    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic                     last;
    } res_t;

    function automatic logic signed [COST_W-1:0] sat_add(
        input logic signed [COST_W-1:0] a,
        input logic signed [COST_W-1:0] b
    );
        logic signed [COST_W:0] s;
        begin
            s = {a[COST_W-1], a} + {b[COST_W-1], b};
            if (s[COST_W] != s[COST_W-1])
                sat_add = s[COST_W] ? {1'b1, {(COST_W-1){1'b0}}}
                                    : {1'b0, {(COST_W-1){1'b1}}};
            else
                sat_add = s[COST_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bmpca_front.sv
// Front part: row tracking, band and window classification, command queue.
`default_nettype none
module bmpca_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [bmpca_pkg::COST_W-1:0]   pixel_cost,
    input  wire logic [bmpca_pkg::ROW_W-1:0]           band_top,
    input  wire logic [bmpca_pkg::ROW_W-1:0]           band_bottom,
    input  wire logic [bmpca_pkg::REACH_W-1:0]         reach,
    input  wire logic                                  image_start,
    input  wire logic [bmpca_pkg::ROWS_W-1:0]          rows_in_use,
    output logic                                       cmd_valid,
    input  wire logic                                  cmd_pop,
    output bmpca_pkg::cmd_t                            cmd
);
    localparam int RW = bmpca_pkg::ROW_W;
    localparam logic [bmpca_pkg::ROWS_W-1:0] ROWS_CAP = bmpca_pkg::ROWS_W'(bmpca_pkg::MAX_ROWS);
    localparam logic [bmpca_pkg::REACH_W:0]  REACH_CAP =
        (bmpca_pkg::REACH_W+1)'(bmpca_pkg::MAX_REACH);

    logic [RW-1:0]                     row_cnt_reg;
    logic                              first_reg;
    logic                              bank_reg;
    logic [RW-1:0]                     prev_top_reg;
    logic [RW-1:0]                     prev_bot_reg;
    logic [bmpca_pkg::REACH_W-1:0]     prev_reach_reg;

    bmpca_pkg::cmd_t                   q_reg [2];
    logic                              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                        cnt_reg;

    logic [bmpca_pkg::ROWS_W-1:0]      rows_eff, rows_m1;
    logic [RW-1:0]                     cnt, row, lo_raw, lo, hi1, hi;
    logic [RW:0]                       hi_raw;
    logic                              first, last, in_band;
    logic [bmpca_pkg::REACH_W-1:0]     reach_sat;
    logic                              accept;
    bmpca_pkg::cmd_t                   new_cmd;

    always_comb
    begin
        if (rows_in_use == '0)
            rows_eff = bmpca_pkg::ROWS_W'(1);
        else if (rows_in_use > ROWS_CAP)
            rows_eff = ROWS_CAP;
        else
            rows_eff = rows_in_use;
        rows_m1 = rows_eff - bmpca_pkg::ROWS_W'(1);

        cnt   = image_start ? '0 : row_cnt_reg;
        first = image_start | first_reg;
        row   = ({1'b0, cnt} > rows_m1) ? rows_m1[RW-1:0] : cnt;
        last  = ({1'b0, cnt} >= rows_m1);

        reach_sat = ({1'b0, reach} > REACH_CAP) ? REACH_CAP[bmpca_pkg::REACH_W-1:0] : reach;

        // window over the previous column, clipped to its band and the rows
        lo_raw = (row >= RW'(prev_reach_reg)) ? row - RW'(prev_reach_reg) : '0;
        lo     = (lo_raw < prev_top_reg) ? prev_top_reg : lo_raw;
        hi_raw = {1'b0, row} + (RW+1)'(prev_reach_reg);
        hi1    = (hi_raw > {1'b0, prev_bot_reg}) ? prev_bot_reg : hi_raw[RW-1:0];
        hi     = (hi1 > rows_m1[RW-1:0]) ? rows_m1[RW-1:0] : hi1;

        in_band = !first && (row >= band_top) && (row <= band_bottom);

        new_cmd.cost    = pixel_cost;
        new_cmd.row     = row;
        new_cmd.lo      = lo;
        new_cmd.hi      = hi;
        new_cmd.in_band = in_band;
        new_cmd.scan    = in_band && (lo <= hi);
        new_cmd.last    = last;
        new_cmd.bank    = bank_reg;
    end

    assign full      = cnt_reg[1];
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= new_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg    <= '0;
            first_reg      <= 1'b1;
            bank_reg       <= 1'b0;
            prev_top_reg   <= '0;
            prev_bot_reg   <= '0;
            prev_reach_reg <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
                if (last)
                begin
                    row_cnt_reg    <= '0;
                    first_reg      <= 1'b0;
                    bank_reg       <= ~bank_reg;
                    prev_top_reg   <= band_top;
                    prev_bot_reg   <= band_bottom;
                    prev_reach_reg <= reach_sat;
                end
                else
                begin
                    row_cnt_reg <= cnt + RW'(1);
                    first_reg   <= first;
                end
            end
            if (cmd_pop && cmd_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(accept) - 2'(cmd_pop && cmd_valid);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/bmpca_back.sv
// Back part: window scan over the column memory, accumulate, result queue.
`default_nettype none
module bmpca_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_pop,
    input  wire bmpca_pkg::cmd_t                       cmd,
    input  wire logic signed [bmpca_pkg::COST_W-1:0]   empty_window_cost,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [bmpca_pkg::COST_W-1:0]        path_cost,
    output logic                                       column_end
);
    localparam int RW = bmpca_pkg::ROW_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

    state_t                               state_reg;
    bmpca_pkg::cmd_t                      cur_reg;
    logic [RW-1:0]                        k_reg;
    logic signed [bmpca_pkg::COST_W-1:0]  best_reg;
    logic                                 rd_vld_reg;
    logic signed [bmpca_pkg::COST_W-1:0]  rd_data_reg;

    // both columns, ping-pong by the top address bit
    logic signed [bmpca_pkg::COST_W-1:0]  mem [2*bmpca_pkg::MAX_ROWS];

    bmpca_pkg::res_t                      q_reg [2];
    logic                                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                           cnt_reg;

    logic                                 start, out_pop, do_rd;
    logic signed [bmpca_pkg::COST_W-1:0]  result;
    bmpca_pkg::res_t                      new_res;

    assign start   = (state_reg == S_IDLE) && cmd_valid && !cnt_reg[1];
    assign cmd_pop = start;
    assign do_rd   = (state_reg == S_SCAN);
    assign out_pop = pop && !empty;

    always_comb
    begin
        result       = cur_reg.in_band ? bmpca_pkg::sat_add(cur_reg.cost, best_reg)
                                       : cur_reg.cost;
        new_res.cost = result;
        new_res.last = cur_reg.last;
    end

    assign empty      = (cnt_reg == 2'd0);
    assign path_cost  = q_reg[rd_ptr_reg].cost;
    assign column_end = q_reg[rd_ptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (do_rd)
            rd_data_reg <= mem[{~cur_reg.bank, k_reg}];
        if (state_reg == S_DONE)
        begin
            mem[{cur_reg.bank, cur_reg.row}] <= result;
            q_reg[wr_ptr_reg] <= new_res;
        end
        if (start)
            cur_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            best_reg   <= '0;
            rd_vld_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_vld_reg <= do_rd;
            if (rd_vld_reg && (rd_data_reg < best_reg))
                best_reg <= rd_data_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        best_reg  <= empty_window_cost;
                        k_reg     <= cmd.lo;
                        state_reg <= cmd.scan ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (k_reg == cur_reg.hi)
                        state_reg <= S_DRAIN;
                    else
                        k_reg <= k_reg + RW'(1);
                end
                S_DRAIN: state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_DONE)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(state_reg == S_DONE) - 2'(out_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/banded_min_path_cost_accumulate.sv
// Top level: config registers, front classifier and back accumulator.
//
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// input    | push / full         | pixel_cost band_top band_bottom reach image_start
// result   | pop / empty         | path_cost column_end
// config   | cfg_write           | cfg_index cfg_data
//
// The back part holds an in-band pixel with a non-empty window while it scans the W
// rows of its clipped window (up to 127 rows); any other pixel skips the scan.
// The single read port of the column memory sets the scan: one window row per cycle.
// Reset clears control state; column memory contents stay undefined.
// Two-entry queues sit between front and back and at the result side.
`default_nettype none
module banded_min_path_cost_accumulate (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [bmpca_pkg::COST_W-1:0]   pixel_cost,
    input  wire logic [bmpca_pkg::ROW_W-1:0]           band_top,
    input  wire logic [bmpca_pkg::ROW_W-1:0]           band_bottom,
    input  wire logic [bmpca_pkg::REACH_W-1:0]         reach,
    input  wire logic                                  image_start,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [bmpca_pkg::COST_W-1:0]        path_cost,
    output logic                                       column_end,
    input  wire logic                                  cfg_write,
    input  wire logic                                  cfg_index,
    input  wire logic [bmpca_pkg::COST_W-1:0]          cfg_data
);
    logic [bmpca_pkg::ROWS_W-1:0]         rows_reg;
    logic signed [bmpca_pkg::COST_W-1:0]  ewc_reg;
    logic                                 cmd_valid, cmd_pop;
    bmpca_pkg::cmd_t                      cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= bmpca_pkg::ROWS_W'(1024);
            ewc_reg  <= {1'b0, {(bmpca_pkg::COST_W-1){1'b1}}};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bmpca_pkg::REG_ROWS_IN_USE:      rows_reg <= cfg_data[bmpca_pkg::ROWS_W-1:0];
                bmpca_pkg::REG_EMPTY_WINDOW_CST: ewc_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    bmpca_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_cost  (pixel_cost),
        .band_top    (band_top),
        .band_bottom (band_bottom),
        .reach       (reach),
        .image_start (image_start),
        .rows_in_use (rows_reg),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    bmpca_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_pop           (cmd_pop),
        .cmd               (cmd),
        .empty_window_cost (ewc_reg),
        .empty             (empty),
        .pop               (pop),
        .path_cost         (path_cost),
        .column_end        (column_end)
    );
endmodule
`default_nettype wire
